// ===== rtl/lbpp_pkg.sv =====
`timescale 1ns / 1ps

package lbpp_pkg;

	localparam int CHANNELS_DEF = 5;
	localparam int OUT_W = 5;
	localparam int CH_W = 3;
	localparam int PAT_W = 8;
	localparam int POS_W = 3;
	localparam int BT_W = 16;
	localparam logic [BT_W-1:0] BT_RESET = 16'd125;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	// Per-channel control for one transaction.
	typedef struct packed {
		logic             en;
		logic             tick;
		logic             load;
		logic [PAT_W-1:0] pattern;
		logic             repeat_req;
		logic [BT_W-1:0]  reload;
	} chan_ctl_t;

	// Per-channel outcome of one transaction.
	typedef struct packed {
		logic level;
		logic finished;
		logic restarted;
	} chan_stat_t;

endpackage

// ===== rtl/lbpp_if.sv =====
`timescale 1ns / 1ps

interface lbpp_item_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [lbpp_pkg::CH_W-1:0]     channel;
	logic [lbpp_pkg::PAT_W-1:0]    pattern;
	logic                          repeat_req;

	modport source (output valid, op, channel, pattern, repeat_req, input ready);
	modport sink (input valid, op, channel, pattern, repeat_req, output ready);
endinterface

interface lbpp_result_if;
	logic                          valid;
	logic                          ready;
	logic [lbpp_pkg::OUT_W-1:0]    drive_levels;
	logic [lbpp_pkg::OUT_W-1:0]    finished_mask;
	logic                          restarted;

	modport source (output valid, drive_levels, finished_mask, restarted, input ready);
	modport sink (input valid, drive_levels, finished_mask, restarted, output ready);
endinterface

// ===== rtl/lbpp_chan.sv =====
`timescale 1ns / 1ps

module lbpp_chan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lbpp_pkg::chan_ctl_t    ctl,
	output lbpp_pkg::chan_stat_t   stat
);

	logic [lbpp_pkg::PAT_W-1:0] pattern_q, pattern_d;
	logic [lbpp_pkg::POS_W-1:0] pos_q, pos_d;
	logic                       loop_q, loop_d;
	logic [lbpp_pkg::BT_W-1:0]  ticks_q, ticks_d;
	logic                       level_q, level_d;
	logic                       same;

	always_comb begin
		pattern_d = pattern_q;
		pos_d = pos_q;
		loop_d = loop_q;
		ticks_d = ticks_q;
		level_d = level_q;
		stat.finished = 1'b0;
		stat.restarted = 1'b0;
		same = ctl.repeat_req && (pattern_q == ctl.pattern) && loop_q;
		if (ctl.load) begin
			if (!same) begin
				ticks_d = '0;
				pos_d = '0;
				pattern_d = ctl.pattern;
				loop_d = ctl.repeat_req;
				stat.restarted = 1'b1;
			end
		end else if (ctl.tick) begin
			if (ticks_q != '0) begin
				ticks_d = ticks_q - 1'b1;
			end else begin
				ticks_d = ctl.reload;
				level_d = pattern_q[pos_q];
				pos_d = pos_q + 1'b1;
				if (pos_q == '1 && !loop_q) begin
					pattern_d = '0;
					stat.finished = 1'b1;
				end
			end
		end
		stat.level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pos_q <= lbpp_pkg::POS_W'(1);
			loop_q <= 1'b0;
			ticks_q <= '0;
			level_q <= 1'b0;
		end else if (ctl.en) begin
			pattern_q <= pattern_d;
			pos_q <= pos_d;
			loop_q <= loop_d;
			ticks_q <= ticks_d;
			level_q <= level_d;
		end
	end

endmodule

// ===== rtl/led_blink_pattern_pacer_top.sv =====
`timescale 1ns / 1ps
// LED and beeper blink pattern pacer.
// Items arrive on the valid/ready channel "items": op selects a time tick or a
// pattern load, and a load carries channel, pattern and repeat_req. Every
// accepted transaction produces exactly one transaction on "results" with the
// output levels of channels 0 to 4, the channels whose one-shot pattern ended
// on this tick, and whether a load restarted its channel.
// The bit time in ticks is written through cfg_we and cfg_wdata; the user must
// do so only while idle, not enforced by the block; zero acts as one.
// An item is registered at acceptance and its result is registered once the
// result register is free, through the per-channel next-state logic between
// the two registers. One item is taken every cycle unless the receiver stalls.
// While the receiver stalls, the result register holds and one more item may
// wait in the input register; then ready drops until the result is taken.
// Reset clears all patterns, sets every channel to bit position one with its
// timer expired, drives all levels low and loads a bit time of 125 ticks.
// Channels above four run normally; only their restarts show on the results.
module led_blink_pattern_pacer_top #(
	parameter int CHANNELS = lbpp_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lbpp_item_if.sink                   items,
	lbpp_result_if.source               results,
	input  logic                        cfg_we,
	input  logic [lbpp_pkg::BT_W-1:0]   cfg_wdata
);

	logic [lbpp_pkg::BT_W-1:0]  bit_time_q;
	logic [lbpp_pkg::BT_W-1:0]  reload;

	logic                       valid_s1;
	lbpp_pkg::op_t              op_s1;
	logic [lbpp_pkg::CH_W-1:0]  channel_s1;
	logic [lbpp_pkg::PAT_W-1:0] pattern_s1;
	logic                       repeat_s1;

	logic                       out_valid_q;
	logic [lbpp_pkg::OUT_W-1:0] levels_q;
	logic [lbpp_pkg::OUT_W-1:0] finished_q;
	logic                       restarted_q;

	logic                       advance;
	lbpp_pkg::chan_ctl_t        ctl [CHANNELS];
	lbpp_pkg::chan_stat_t       stat [CHANNELS];
	logic [lbpp_pkg::OUT_W-1:0] levels_d;
	logic [lbpp_pkg::OUT_W-1:0] finished_d;
	logic                       restarted_d;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign reload = (bit_time_q == '0) ? '0 : bit_time_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q <= lbpp_pkg::BT_RESET;
		end else if (cfg_we) begin
			bit_time_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1 <= lbpp_pkg::op_t'(items.op);
			channel_s1 <= items.channel;
			pattern_s1 <= items.pattern;
			repeat_s1 <= items.repeat_req;
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		always_comb begin
			ctl[i].en = advance;
			ctl[i].tick = (op_s1 == lbpp_pkg::OP_TICK);
			ctl[i].load = (op_s1 == lbpp_pkg::OP_LOAD) && (32'(channel_s1) == i);
			ctl[i].pattern = pattern_s1;
			ctl[i].repeat_req = repeat_s1;
			ctl[i].reload = reload;
		end

		lbpp_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.stat   (stat[i])
		);
	end

	for (genvar b = 0; b < lbpp_pkg::OUT_W; b++) begin : g_out
		if (b < CHANNELS) begin : g_used
			assign levels_d[b] = stat[b].level;
			assign finished_d[b] = stat[b].finished;
		end else begin : g_unused
			assign levels_d[b] = 1'b0;
			assign finished_d[b] = 1'b0;
		end
	end

	always_comb begin
		restarted_d = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			restarted_d = restarted_d | stat[i].restarted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			levels_q <= levels_d;
			finished_q <= finished_d;
			restarted_q <= restarted_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.drive_levels = levels_q;
	assign results.finished_mask = finished_q;
	assign results.restarted = restarted_q;

	a_tick_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == lbpp_pkg::OP_TICK) |=> !restarted_q)
		else $error("tick transaction reported a restart");

	a_load_no_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == lbpp_pkg::OP_LOAD) |=> (finished_q == '0))
		else $error("load transaction reported a finished channel");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a registered item");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> items.ready)
		else $error("input stalled with an empty result register");

endmodule

// ===== bench/tb_led_blink_pattern_pacer_top.sv =====
`timescale 1ns / 1ps

module tb_led_blink_pattern_pacer_top;

	localparam int NUM_CH = lbpp_pkg::CHANNELS_DEF;

	typedef struct packed {
		logic [lbpp_pkg::OUT_W-1:0] levels;
		logic [lbpp_pkg::OUT_W-1:0] finished;
		logic                       restarted;
	} pacer_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lbpp_pkg::BT_W-1:0] cfg_wdata;

	lbpp_item_if   item_ch ();
	lbpp_result_if result_ch ();

	led_blink_pattern_pacer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the pacer state.
	logic [lbpp_pkg::PAT_W-1:0] ch_pat [NUM_CH];
	logic [lbpp_pkg::POS_W-1:0] ch_pos [NUM_CH];
	logic                       ch_loop [NUM_CH];
	logic [lbpp_pkg::BT_W-1:0]  ch_wait [NUM_CH];
	logic [NUM_CH-1:0]          level_mdl;
	logic [lbpp_pkg::BT_W-1:0]  bit_time_mdl;

	pacer_result_t expected_results [$];
	int  error_count;
	bit  idle_en;
	int  hold_len;
	bit  holding;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void reset_pacer_model();
		for (int i = 0; i < NUM_CH; i++) begin
			ch_pat[i] = '0;
			ch_pos[i] = lbpp_pkg::POS_W'(1);
			ch_loop[i] = 1'b0;
			ch_wait[i] = '0;
		end
		level_mdl = '0;
		bit_time_mdl = lbpp_pkg::BT_RESET;
	endfunction

	function automatic pacer_result_t step_pacer(lbpp_pkg::op_t op,
			logic [lbpp_pkg::CH_W-1:0] ch, logic [lbpp_pkg::PAT_W-1:0] pat, logic rep);
		pacer_result_t r;
		logic [NUM_CH-1:0] fin;
		logic rst;
		fin = '0;
		rst = 1'b0;
		if (op == lbpp_pkg::OP_LOAD) begin
			if (ch < NUM_CH) begin
				if (!(rep && ch_pat[ch] == pat && ch_loop[ch])) begin
					ch_wait[ch] = '0;
					ch_pos[ch] = '0;
					ch_pat[ch] = pat;
					ch_loop[ch] = rep;
					rst = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (ch_wait[i] != 0) begin
					ch_wait[i] = ch_wait[i] - 1'b1;
				end else begin
					ch_wait[i] = (bit_time_mdl == 0) ? '0 : bit_time_mdl - 1'b1;
					level_mdl[i] = ch_pat[i][ch_pos[i]];
					ch_pos[i] = ch_pos[i] + 1'b1;
					if (ch_pos[i] == 0 && !ch_loop[i]) begin
						ch_pat[i] = '0;
						fin[i] = 1'b1;
					end
				end
			end
		end
		r.levels = level_mdl[lbpp_pkg::OUT_W-1:0];
		r.finished = fin[lbpp_pkg::OUT_W-1:0];
		r.restarted = rst;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
		$display("MISMATCH at %0t: %s expected %0h, got %0h", $realtime, field, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		pacer_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transaction", 8'h00, 8'h01);
			end else begin
				want = expected_results.pop_front();
				if (result_ch.drive_levels !== want.levels)
					report_mismatch("drive_levels", 8'(want.levels),
						8'(result_ch.drive_levels));
				if (result_ch.finished_mask !== want.finished)
					report_mismatch("finished_mask", 8'(want.finished),
						8'(result_ch.finished_mask));
				if (result_ch.restarted !== want.restarted)
					report_mismatch("restarted", 8'(want.restarted),
						8'(result_ch.restarted));
			end
		end
	end

	initial begin
		int n;
		forever begin
			if (hold_len > 0) begin
				result_ch.ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				holding = 1'b1;
				repeat (n) @(posedge clk);
				holding = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_item(lbpp_pkg::op_t op, logic [lbpp_pkg::CH_W-1:0] ch,
			logic [lbpp_pkg::PAT_W-1:0] pat, logic rep);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.channel <= ch;
		item_ch.pattern <= pat;
		item_ch.repeat_req <= rep;
		do @(posedge clk); while (!item_ch.ready);
		expected_results.push_back(step_pacer(op, ch, pat, rep));
	endtask

	task automatic send_tick();
		send_item(lbpp_pkg::OP_TICK, lbpp_pkg::CH_W'($urandom_range(0, 7)),
			lbpp_pkg::PAT_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_bit_time(logic [lbpp_pkg::BT_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_time_mdl = value;
	endtask

	task automatic test_reset_state();
		repeat (3) send_tick();
		send_item(lbpp_pkg::OP_LOAD, 3'd0, 8'h01, 1'b0);
		repeat (3) send_tick();
	endtask

	// Loads to every channel with edge patterns, then ticks through a full cycle.
	task automatic test_directed_patterns();
		write_bit_time(16'd1);
		send_item(lbpp_pkg::OP_LOAD, 3'd0, 8'hFF, 1'b0);
		send_item(lbpp_pkg::OP_LOAD, 3'd1, 8'h00, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd2, 8'hA5, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd3, 8'h5A, 1'b0);
		send_item(lbpp_pkg::OP_LOAD, 3'd4, 8'h80, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd5, 8'hFF, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd6, 8'h01, 1'b0);
		send_item(lbpp_pkg::OP_LOAD, 3'd7, 8'h3C, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd2, 8'hA5, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd2, 8'hA5, 1'b0);
		repeat (9) send_tick();
		send_item(lbpp_pkg::OP_LOAD, 3'd4, 8'h80, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd4, 8'h7F, 1'b1);
		repeat (3) send_tick();
	endtask

	task automatic test_zero_bit_time();
		write_bit_time(16'd0);
		send_item(lbpp_pkg::OP_LOAD, 3'd1, 8'h55, 1'b0);
		send_item(lbpp_pkg::OP_LOAD, 3'd3, 8'hC3, 1'b1);
		repeat (10) send_tick();
	endtask

	task automatic test_max_bit_time();
		write_bit_time(16'hFFFF);
		send_item(lbpp_pkg::OP_LOAD, 3'd0, 8'hAA, 1'b1);
		send_item(lbpp_pkg::OP_LOAD, 3'd4, 8'h01, 1'b0);
		repeat (20) send_tick();
		write_bit_time(16'd2);
		repeat (6) send_tick();
	endtask

	// The receiver stalls long enough for the input side to back up.
	task automatic test_result_stall();
		wait_drained();
		hold_len = 300;
		while (!holding) @(posedge clk);
		repeat (30) begin
			if ($urandom_range(0, 3) == 0)
				send_item(lbpp_pkg::OP_LOAD, lbpp_pkg::CH_W'($urandom_range(0, 4)),
					lbpp_pkg::PAT_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			else
				send_tick();
		end
		wait_drained();
	endtask

	task automatic run_random(int count, logic [lbpp_pkg::BT_W-1:0] bit_time);
		int kind;
		logic [lbpp_pkg::CH_W-1:0] ch;
		write_bit_time(bit_time);
		repeat (count) begin
			kind = $urandom_range(0, 99);
			ch = lbpp_pkg::CH_W'($urandom_range(0, NUM_CH - 1));
			if (kind < 72) begin
				send_tick();
			end else if (kind < 90) begin
				send_item(lbpp_pkg::OP_LOAD, ch, lbpp_pkg::PAT_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (kind < 96) begin
				send_item(lbpp_pkg::OP_LOAD, ch, ch_pat[ch], 1'b1);
			end else begin
				send_item(lbpp_pkg::OP_LOAD, lbpp_pkg::CH_W'($urandom_range(0, 7)),
					lbpp_pkg::PAT_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.op <= lbpp_pkg::OP_TICK;
		item_ch.channel <= '0;
		item_ch.pattern <= '0;
		item_ch.repeat_req <= 1'b0;
		error_count = 0;
		hold_len = 0;
		holding = 1'b0;
		idle_en = 1'b1;
		reset_pacer_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_patterns();
		test_zero_bit_time();
		test_max_bit_time();
		test_result_stall();
		run_random(400, 16'd1);
		run_random(300, 16'd2);
		run_random(250, 16'd3);
		run_random(200, 16'd0);
		run_random(250, lbpp_pkg::BT_W'($urandom_range(1, 6)));
		test_result_stall();
		idle_en = 1'b0;
		run_random(200, 16'd1);

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== led_blink_pattern_pacer_top.f =====
rtl/lbpp_pkg.sv
rtl/lbpp_if.sv
rtl/lbpp_chan.sv
rtl/led_blink_pattern_pacer_top.sv
bench/tb_led_blink_pattern_pacer_top.sv
